[rtl/core/gpb_pkg.sv]
// Shared types, constants and the base64url character map for the geo point encoder.
// No dependencies; every other file in rtl/core imports this package.
package gpb_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int COORD_BITS_DEF = 30;

  localparam int CNT_W  = 4;
  localparam int CHAR_W = 7;

  localparam logic [CNT_W-1:0] DCNT_RESET = 4'd9;

  // 1e-7 degree units
  localparam logic [63:0] LAT_HALF = 64'd900000000;
  localparam logic [63:0] LON_HALF = 64'd1800000000;

  // 1.8e9 = K << 9 and 3.6e9 = K << 10; both divisions end as a division by K
  localparam int          LAT_SHIFT  = 9;
  localparam int          LON_SHIFT  = 10;
  localparam int          DIV_K_W    = 22;
  localparam logic [21:0] DIV_K      = 22'd3515625;
  // dividend bits dropped before the reciprocal multiply
  localparam int          DIV_LOW    = 21;
  // floor(2^(DIV_LOW+32) / K)
  localparam logic [31:0] DIV_M      = 32'd2562047788;
  localparam int          DIV_STAGES = 3;

  typedef struct packed {
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
  } geo_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code_char;
    logic [CNT_W-1:0]  digit_index;
    logic              last_digit;
  } geo_out_t;

  // A-Z a-z 0-9 '-' '_'
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd26) begin
      c = 8'd65 + {2'b00, d};
    end else if (d < 6'd52) begin
      c = 8'd71 + {2'b00, d};
    end else if (d < 6'd62) begin
      c = {2'b00, d} - 8'd4;
    end else if (d == 6'd62) begin
      c = 8'd45;
    end else begin
      c = 8'd95;
    end
    return c[CHAR_W-1:0];
  endfunction

endpackage

[rtl/core/geo_point_base64_encoder_top.sv]
// Geo point to base64url encoder, top level: input register, dividend stage,
// two pipelined constant dividers and the digit serializer. Uses gpb_pkg.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | one point (lat, lon) per item
//  result  | out_valid, out_ready, out_data | one character per item
//  config  | cfg_we, cfg_wdata              | digit count, no read-back
//
//  Before its first character leaves, a point passes the input register,
//  dividend register, 3 divider stages (estimate, remainder, correction),
//  then the serializer.
//  The result port sends one character per cycle while out_ready is high;
//  a point gives n = min(digit count, MAX_DIGITS) characters, and none for n = 0.
//  The pipeline stalls as a whole while the serializer holds characters;
//  the input register still takes a point when it is empty.
//  Reset clears all valid bits and sets the digit count to 9.
module geo_point_base64_encoder_top #(
  parameter int MAX_DIGITS = gpb_pkg::MAX_DIGITS_DEF,
  parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gpb_pkg::geo_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gpb_pkg::geo_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [gpb_pkg::CNT_W-1:0] cfg_wdata
);
  import gpb_pkg::*;

  localparam int QW    = COORD_BITS + 1;
  localparam int NUM_W = QW + DIV_LOW;

  logic             adv;
  logic [CNT_W-1:0] dcnt_r;

  logic             in_v_r;
  geo_in_t          in_pt_r;

  logic             num_v_r;
  logic [NUM_W-1:0] lat_num, lon_num;
  logic [NUM_W-1:0] lat_num_r, lon_num_r;

  logic [DIV_STAGES-1:0] dv_r;
  logic [QW-1:0]         lat_q, lon_q;

  assign in_ready = adv || !in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r  <= DCNT_RESET;
      in_v_r  <= 1'b0;
      num_v_r <= 1'b0;
      dv_r    <= '0;
    end else begin
      if (cfg_we) begin
        dcnt_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        num_v_r <= in_v_r;
        dv_r    <= {dv_r[DIV_STAGES-2:0], num_v_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_pt_r <= in_data;
    end
    if (adv) begin
      lat_num_r <= lat_num;
      lon_num_r <= lon_num;
    end
  end

  gpb_prep #(
    .COORD_BITS(COORD_BITS),
    .NUM_W     (NUM_W)
  ) u_prep (
    .pt     (in_pt_r),
    .lat_num(lat_num),
    .lon_num(lon_num)
  );

  gpb_div #(
    .QW(QW)
  ) u_lat_div (
    .clk(clk),
    .en (adv),
    .num(lat_num_r),
    .quo(lat_q)
  );

  gpb_div #(
    .QW(QW)
  ) u_lon_div (
    .clk(clk),
    .en (adv),
    .num(lon_num_r),
    .quo(lon_q)
  );

  // lat quotient stays below 2^CB; lon may hit 2^CB, which wraps to 0
  gpb_emit #(
    .MAX_DIGITS(MAX_DIGITS),
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_v     (dv_r[DIV_STAGES-1]),
    .lat_code   (lat_q[COORD_BITS-1:0]),
    .lon_code   (lon_q[COORD_BITS-1:0]),
    .digit_count(dcnt_r),
    .take       (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && dv_r[DIV_STAGES-1]) |=> dv_r[DIV_STAGES-1])
    else $error("item dropped at divider output during stall");

  a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && in_v_r) |=> in_v_r && $stable(in_pt_r))
    else $error("input register lost an item during stall");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !adv)
    else $error("pipeline advanced while a character waits");

endmodule

[rtl/core/gpb_prep.sv]
// Coordinate conditioning: latitude clamp, longitude wrap, and the scaled
// dividends for the constant dividers. Combinational; uses gpb_pkg.
module gpb_prep #(
  parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF,
  parameter int NUM_W      = COORD_BITS + 1 + gpb_pkg::DIV_LOW
) (
  input  gpb_pkg::geo_in_t   pt,
  output logic [NUM_W-1:0]   lat_num,
  output logic [NUM_W-1:0]   lon_num
);
  import gpb_pkg::*;

  localparam int LW = NUM_W + LAT_SHIFT;
  localparam int OW = NUM_W + LON_SHIFT;

  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [33:0] LON_OFF = 34'sd1800000000;
  localparam logic signed [33:0] LON_SPAN = 34'sd3600000000;

  logic signed [31:0] lat_c;
  logic [31:0]        lat_off;
  logic [LW-1:0]      off_w;
  logic [LW-1:0]      lat_t;
  logic signed [33:0] lon_t;
  logic signed [33:0] lon_wrap;
  logic [31:0]        lon_r;
  logic [OW-1:0]      lon_sc;

  always_comb begin
    if (pt.latitude < LAT_MIN) begin
      lat_c = LAT_MIN;
    end else if (pt.latitude > LAT_MAX) begin
      lat_c = LAT_MAX;
    end else begin
      lat_c = pt.latitude;
    end
    lat_off = 32'(lat_c + LAT_MAX);          // 0 .. 1.8e9
    off_w   = LW'(lat_off);
    // off * (2^CB - 1) + half divisor, floored by 2^LAT_SHIFT
    lat_t   = (off_w << COORD_BITS) - off_w + LW'(LAT_HALF);
    lat_num = lat_t[LW-1 -: NUM_W];

    lon_t = {{2{pt.longitude[31]}}, pt.longitude} + LON_OFF;
    if (lon_t[33]) begin
      lon_wrap = lon_t + LON_SPAN;
    end else if (lon_t >= LON_SPAN) begin
      lon_wrap = lon_t - LON_SPAN;
    end else begin
      lon_wrap = lon_t;
    end
    lon_r   = lon_wrap[31:0];                // 0 .. 3.6e9-1
    lon_sc  = (OW'(lon_r) << COORD_BITS) + OW'(LON_HALF);
    lon_num = lon_sc[OW-1 -: NUM_W];
  end

endmodule

[rtl/core/gpb_div.sv]
// Divider by the constant K of gpb_pkg: reciprocal estimate, remainder, and a
// correction of up to two, one register stage each. Uses gpb_pkg.
module gpb_div #(
  parameter int QW = gpb_pkg::COORD_BITS_DEF + 1
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [QW+gpb_pkg::DIV_LOW-1:0] num,
  output logic [QW-1:0]                  quo
);
  import gpb_pkg::*;

  localparam int NUM_W = QW + DIV_LOW;
  localparam int PW    = QW + 32;
  localparam int RMW   = DIV_K_W + 2;     // remainder stays below 3 * K
  localparam logic [RMW-1:0] K1 = RMW'(DIV_K);
  localparam logic [RMW-1:0] K2 = RMW'({DIV_K, 1'b0});

  logic [PW-1:0]  est_prod;
  logic [RMW-1:0] ek;
  logic [RMW-1:0] rem;
  logic [1:0]     fix;

  logic [QW-1:0]  est_b_r, est_c_r;
  logic [RMW-1:0] lo_b_r, lo_c_r, ek_c_r;
  logic [QW-1:0]  quo_r;

  // top dividend bits times the reciprocal; estimate is short by at most two
  assign est_prod = PW'(num[NUM_W-1 -: QW]) * PW'(DIV_M);
  // low bits of est * K are enough, the true remainder is below 3 * K
  assign ek       = RMW'(est_b_r) * K1;
  assign rem      = lo_c_r - ek_c_r;

  always_comb begin
    if (rem >= K2) begin
      fix = 2'd2;
    end else if (rem >= K1) begin
      fix = 2'd1;
    end else begin
      fix = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est_b_r <= est_prod[PW-1 -: QW];
      lo_b_r  <= num[RMW-1:0];
      est_c_r <= est_b_r;
      lo_c_r  <= lo_b_r;
      ek_c_r  <= ek;
      quo_r   <= est_c_r + QW'(fix);
    end
  end

  assign quo = quo_r;

endmodule

[rtl/core/gpb_emit.sv]
// Digit serializer: interleaves three lat and three lon bits per digit and
// sends one base64url character per cycle while out_ready is high. Uses gpb_pkg.
module gpb_emit #(
  parameter int MAX_DIGITS = gpb_pkg::MAX_DIGITS_DEF,
  parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_v,
  input  logic [COORD_BITS-1:0]       lat_code,
  input  logic [COORD_BITS-1:0]       lon_code,
  input  logic [gpb_pkg::CNT_W-1:0]   digit_count,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gpb_pkg::geo_out_t           out_data
);
  import gpb_pkg::*;

  localparam int AW = 3 * MAX_DIGITS;
  localparam logic [CNT_W-1:0] MAXD = CNT_W'(MAX_DIGITS);

  logic                  busy_r,  busy_nxt;
  logic [CNT_W-1:0]      idx_r,   idx_nxt;
  logic [CNT_W-1:0]      last_r,  last_nxt;
  logic [AW-1:0]         la_sh_r, la_sh_nxt;
  logic [AW-1:0]         lo_sh_r, lo_sh_nxt;

  logic [AW+COORD_BITS-1:0] la_ext, lo_ext;
  logic [CNT_W-1:0]         n_dig;
  logic                     is_last;
  logic [2:0]               a, b;

  // coordinate left-aligned in the digit stream, zeros below bit 0
  assign la_ext  = {lat_code, {AW{1'b0}}};
  assign lo_ext  = {lon_code, {AW{1'b0}}};
  assign n_dig   = (digit_count > MAXD) ? MAXD : digit_count;
  assign is_last = (idx_r == last_r);
  assign take    = !busy_r || (out_ready && is_last);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    la_sh_nxt = la_sh_r;
    lo_sh_nxt = lo_sh_r;
    if (take) begin
      busy_nxt  = item_v && (n_dig != '0);
      idx_nxt   = '0;
      last_nxt  = n_dig - 1'b1;
      la_sh_nxt = la_ext[AW+COORD_BITS-1 -: AW];
      lo_sh_nxt = lo_ext[AW+COORD_BITS-1 -: AW];
    end else if (out_ready) begin
      idx_nxt   = idx_r + 1'b1;
      la_sh_nxt = la_sh_r << 3;
      lo_sh_nxt = lo_sh_r << 3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      last_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_sh_r <= la_sh_nxt;
    lo_sh_r <= lo_sh_nxt;
  end

  assign a = la_sh_r[AW-1 -: 3];
  assign b = lo_sh_r[AW-1 -: 3];

  assign out_valid            = busy_r;
  assign out_data.code_char   = b64_char({a[2], b[2], a[1], b[1], a[0], b[0]});
  assign out_data.digit_index = idx_r;
  assign out_data.last_digit  = is_last;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < MAXD) && (last_r < MAXD))
    else $error("digit index out of range");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_ready && !is_last) |=> busy_r && (idx_r == $past(idx_r) + 1'b1))
    else $error("digit sequence skipped or stalled");

  a_new_item: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item_v && (n_dig != '0)) |=> busy_r && (idx_r == '0))
    else $error("loaded item does not start at digit zero");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (n_dig == '0)) |=> !busy_r)
    else $error("item with zero digits produced output");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for geo_point_base64_encoder_top: drives points, predicts the
// base64url characters of each point and compares them item by item.
// Depends on gpb_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb_top;
  import gpb_pkg::*;

  localparam int C_BITS       = COORD_BITS_DEF;
  localparam int MAX_CHARS    = MAX_DIGITS_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_WAIT   = 40;   // longer than the pipeline depth
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_POINTS = 76;

  // Expected character stream of the accepted points
  class geo_char_tracker;
    geo_out_t         pending_chars[$];
    bit [CNT_W-1:0]   digit_count;
    int unsigned      errors;
    string            alphabet;

    function new();
      digit_count = DCNT_RESET;
      errors      = 0;
      alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    endfunction

    function void set_count(bit [CNT_W-1:0] v);
      digit_count = v;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function longint unsigned lat_code(logic signed [31:0] lat);
      longint l;
      longint unsigned off, maxv;
      l = lat;
      if (l < -64'sd900000000) l = -64'sd900000000;
      if (l > 64'sd900000000) l = 64'sd900000000;
      off  = longint'(l + 64'sd900000000);
      maxv = (64'd1 << C_BITS) - 64'd1;
      return (2 * off * maxv + 64'd1800000000) / 64'd3600000000;
    endfunction

    function longint unsigned lon_code(logic signed [31:0] lon);
      longint r;
      longint unsigned steps, n;
      steps = 64'd1 << C_BITS;
      r = (longint'(lon) + 64'sd1800000000) % 64'sd3600000000;
      if (r < 0) r += 64'sd3600000000;
      n = (longint'(r) * steps * 2 + 64'd3600000000) / 64'd7200000000;
      return (n >= steps) ? 64'd0 : n;
    endfunction

    // three bits for digit i, left-aligned, zeros below bit 0
    function bit [2:0] tri_bits(longint unsigned v, int i);
      int p;
      p = C_BITS - 3 * (i + 1);
      if (p >= 0) return 3'((v >> p) & 7);
      if (p > -3) return 3'((v << (-p)) & 7);
      return 3'd0;
    endfunction

    function void add_point(geo_in_t pt);
      longint unsigned la, lo;
      int              n;
      bit [2:0]        a, b;
      bit [5:0]        d;
      byte             ch;
      geo_out_t        e;
      la = lat_code(pt.latitude);
      lo = lon_code(pt.longitude);
      n  = (digit_count > MAX_CHARS) ? MAX_CHARS : int'(digit_count);
      for (int i = 0; i < n; i++) begin
        a  = tri_bits(la, i);
        b  = tri_bits(lo, i);
        d  = {a[2], b[2], a[1], b[1], a[0], b[0]};
        ch = alphabet[d];
        e.code_char   = ch[CHAR_W-1:0];
        e.digit_index = CNT_W'(i);
        e.last_digit  = (i == n - 1);
        pending_chars.push_back(e);
      end
    endfunction

    function void check_char(geo_out_t got);
      geo_out_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char, got code_char %0d digit_index %0d last_digit %0b",
                 $time, got.code_char, got.digit_index, got.last_digit);
        errors++;
        return;
      end
      e = pending_chars.pop_front();
      if (got.code_char !== e.code_char) begin
        $display("%0t: code_char mismatch, expected %0d got %0d",
                 $time, e.code_char, got.code_char);
        errors++;
      end
      if (got.digit_index !== e.digit_index) begin
        $display("%0t: digit_index mismatch, expected %0d got %0d",
                 $time, e.digit_index, got.digit_index);
        errors++;
      end
      if (got.last_digit !== e.last_digit) begin
        $display("%0t: last_digit mismatch, expected %0b got %0b",
                 $time, e.last_digit, got.last_digit);
        errors++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  geo_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  geo_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;

  geo_char_tracker tracker = new();

  int  send_idle_pct = 11;
  int  recv_idle_pct = 50;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  stall_cycles  = 0;

  geo_point_base64_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic geo_in_t mk_point(int lat, int lon);
    geo_in_t pt;
    pt.latitude  = lat;
    pt.longitude = lon;
    return pt;
  endfunction

  function automatic geo_in_t rand_point();
    int lat_edges[5] = '{900000000, -900000000, 0, 2147483647, -2147483648};
    int lon_edges[6] = '{1800000000, -1800000000, 1799999999, 0, 2147483647, -2147483648};
    int lat, lon;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        lat = int'($urandom_range(0, 1800000000)) - 900000000;
        lon = int'(longint'($urandom_range(0, 32'd3599999999)) - 64'sd1800000000);
      end
      5, 6: begin
        lat = $urandom;
        lon = $urandom;
      end
      7, 8: begin
        lat = lat_edges[$urandom_range(0, 4)] + int'($urandom_range(0, 6)) - 3;
        lon = lon_edges[$urandom_range(0, 5)] + int'($urandom_range(0, 6)) - 3;
      end
      default: begin
        // longitudes that round up to the top code and wrap to zero
        lat = $urandom;
        lon = $urandom_range(0, 1) ? 1799999999 : -1800000001;
      end
    endcase
    return mk_point(lat, lon);
  endfunction

  task automatic send_point(geo_in_t pt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    tracker.add_point(pt);
  endtask

  task automatic write_count(bit [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_count(v);
  endtask

  // wait for every expected char, then let any zero-char point clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(bit [CNT_W-1:0] cnt, int s_idle, int r_idle, bit hold);
    settle();
    write_count(cnt);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    hold_req      = hold;
    repeat (PHASE_POINTS) send_point(rand_point());
  endtask

  // result side: check accepted chars, drive ready, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_char(out_data);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** geo_point_base64_encoder_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, saturation, wrap, top-code wrap
    write_count(4'd10);
    send_point(mk_point(0, 0));
    send_point(mk_point(900000000, 1799999999));
    send_point(mk_point(-900000000, -1800000000));
    send_point(mk_point(900000001, 1800000000));
    send_point(mk_point(-900000001, -1800000001));
    send_point(mk_point(2147483647, 2147483647));
    send_point(mk_point(-2147483648, -2147483648));
    send_point(mk_point(1, -1));
    send_point(mk_point(450000000, 900000000));
    send_point(mk_point(-1, 1799999998));

    // zero digits: points leave no chars
    settle();
    write_count(4'd0);
    send_point(mk_point(12345678, -87654321));
    send_point(mk_point(-2147483648, 2147483647));

    // count above the maximum saturates
    settle();
    write_count(4'd15);
    send_point(mk_point(2147483647, -2147483648));
    send_point(mk_point(0, 1799999999));

    settle();
    write_count(4'd1);
    send_point(mk_point(900000000, 0));
    send_point(mk_point(-900000000, 1799999999));

    run_phase(4'd1,  11, 50, 1'b0);
    run_phase(4'd10, 11, 50, 1'b0);
    run_phase(4'd4,  50, 11, 1'b0);
    run_phase(4'd13, 50, 11, 1'b0);
    run_phase(4'd7,   0,  0, 1'b1);
    run_phase(4'd9,   0,  0, 1'b0);

    settle();
    if (tracker.errors == 0) begin
      $display("** geo_point_base64_encoder_top: PASSED **");
    end else begin
      $display("** geo_point_base64_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gpb_pkg.sv
rtl/core/gpb_prep.sv
rtl/core/gpb_div.sv
rtl/core/gpb_emit.sv
rtl/core/geo_point_base64_encoder_top.sv
tb/tb_top.sv
